### hw/rtl/tws_pkg.sv
// package for the timing wheel scheduler
// sizes, result kinds and controller states; no dependencies
package tws_pkg;

  localparam int NumSlots    = 10;
  localparam int PoolEntries = 32;
  localparam int SlotW       = 4;
  localparam int HandleW     = 5;
  localparam int RotW        = 28;
  localparam int TagW        = 16;
  localparam int IntvW       = 16;
  localparam int TimeoutW    = 32;
  localparam int KindW       = 3;
  localparam int CntW        = 6;

  // reciprocal of the slot count, exact for non-negative timeouts
  localparam int SlotShift = TimeoutW - 1 + $clog2(NumSlots);
  localparam logic [TimeoutW:0] SlotRecip =
    (TimeoutW+1)'(((64'd1 << SlotShift) + 64'(NumSlots) - 64'd1) / 64'(NumSlots));

  typedef enum logic [KindW-1:0] {
    KIND_ADDED    = 3'd0,
    KIND_REJ_NEG  = 3'd1,
    KIND_REJ_FULL = 3'd2,
    KIND_EXPIRED  = 3'd3,
    KIND_DONE     = 3'd4
  } kind_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DIV,
    ST_MOD,
    ST_SLOT,
    ST_ADD_WR,
    ST_SCAN_RD,
    ST_SCAN_EX,
    ST_DONE,
    ST_OUT
  } state_t;

endpackage

### hw/rtl/timing_wheel_scheduler_unit.sv
// timing wheel scheduler top level
// one entry memory with a registered read, a bit-serial divider and a sequencer
// depends on tws_pkg
//
// usage: in_command 0 adds a timer (in_timeout, in_tag); 1 advances the wheel.
// results leave on the out_ channel as words, with out_last on the final word
// of each item. an add gives one word; a tick gives one word per expiring
// entry of the current slot, in ascending handle order, then a done word.
// an add runs a restoring division of the timeout by the slot interval, then
// splits the ticks by the slot count with a reciprocal multiply, then finds
// the slot and writes the entry. a tick reads each pool entry from memory,
// then checks it and writes it back; it waits on the receiver before each
// expired or done word.
// one item is worked on at a time; in_ready is high only when idle.
// the output register holds a word until out_ready; while the receiver stalls
// the sequencer waits with it. reset clears the valid bits, the current slot
// and sets the slot interval to 1; entry memory contents need no clearing.
// cfg_wr_en writes the slot interval; zero acts as one.
module timing_wheel_scheduler_unit (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_wr_en,
  input  logic [tws_pkg::IntvW-1:0]     cfg_wr_data,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          in_command,
  input  logic signed [tws_pkg::TimeoutW-1:0] in_timeout,
  input  logic [tws_pkg::TagW-1:0]      in_tag,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [tws_pkg::KindW-1:0]     out_kind,
  output logic [tws_pkg::HandleW-1:0]   out_handle,
  output logic [tws_pkg::TagW-1:0]      out_expired_tag,
  output logic [tws_pkg::SlotW-1:0]     out_wheel_slot,
  output logic                          out_last
);
  import tws_pkg::*;

  localparam int EntW = RotW + SlotW + TagW;

  logic [EntW-1:0] mem [PoolEntries];
  logic [EntW-1:0] rd_data_r;
  logic            mem_we;
  logic [HandleW-1:0] mem_addr;
  logic [EntW-1:0] mem_wdata;

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_addr] <= mem_wdata;
    rd_data_r <= mem[mem_addr];
  end

  state_t state_r, state_nxt;
  logic [PoolEntries-1:0] valid_r, valid_nxt;
  logic [SlotW-1:0]   cur_r, cur_nxt;
  logic [IntvW-1:0]   intv_r;
  logic [TimeoutW-1:0] quo_r, quo_nxt;
  logic [IntvW:0]     rem_r, rem_nxt;
  logic [CntW-1:0]    cnt_r, cnt_nxt;
  logic [TagW-1:0]    tag_r, tag_nxt;
  logic [HandleW-1:0] free_r, free_nxt;
  logic [RotW-1:0]    rot_r, rot_nxt;
  logic [SlotW-1:0]   slot_r, slot_nxt;
  logic               ov_r, ov_nxt;
  logic [KindW-1:0]   ok_r, ok_nxt;
  logic [HandleW-1:0] oh_r, oh_nxt;
  logic [TagW-1:0]    ot_r, ot_nxt;
  logic [SlotW-1:0]   os_r, os_nxt;
  logic               ol_r, ol_nxt;

  logic [IntvW-1:0]   divisor;
  logic [IntvW:0]     trial;
  logic [IntvW:0]     rem_sh;
  logic [2*TimeoutW:0] prod;
  logic [SlotW-1:0]   mod_s;
  logic [SlotW+1:0]   slot_sum;
  logic [RotW-1:0]    e_rot;
  logic [SlotW-1:0]   e_slot;
  logic [TagW-1:0]    e_tag;
  logic               has_free;
  logic [HandleW-1:0] free_idx;
  logic [HandleW-1:0] idx;

  assign divisor = (intv_r == '0) ? IntvW'(1) : intv_r;
  assign rem_sh  = {rem_r[IntvW-1:0], quo_r[TimeoutW-1]};
  assign trial   = rem_sh - {1'b0, divisor};
  // ticks times the reciprocal, rotation is the product shifted down
  assign prod    = (2*TimeoutW+1)'(quo_r) * (2*TimeoutW+1)'(SlotRecip);
  // remainder from the low bits of ticks and of rotation times the slot count
  assign mod_s   = quo_r[SlotW-1:0] - SlotW'(rot_r[SlotW-1:0] * SlotW'(NumSlots));
  assign slot_sum = (SlotW+2)'(cur_r) + (SlotW+2)'(mod_s);
  assign {e_rot, e_slot, e_tag} = rd_data_r;
  assign idx = cnt_r[HandleW-1:0];

  always_comb begin
    has_free = 1'b0;
    free_idx = '0;
    for (int i = PoolEntries - 1; i >= 0; i--) begin
      if (!valid_r[i]) begin
        has_free = 1'b1;
        free_idx = HandleW'(i);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      intv_r <= IntvW'(1);
    end else if (cfg_wr_en) begin
      intv_r <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      valid_r <= '0;
      cur_r   <= '0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      valid_r <= valid_nxt;
      cur_r   <= cur_nxt;
      ov_r    <= ov_nxt;
    end
    quo_r <= quo_nxt; rem_r <= rem_nxt; cnt_r <= cnt_nxt; tag_r <= tag_nxt;
    free_r <= free_nxt; rot_r <= rot_nxt; slot_r <= slot_nxt;
    ok_r <= ok_nxt; oh_r <= oh_nxt; ot_r <= ot_nxt; os_r <= os_nxt; ol_r <= ol_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    valid_nxt = valid_r;
    cur_nxt = cur_r;
    quo_nxt = quo_r; rem_nxt = rem_r; cnt_nxt = cnt_r; tag_nxt = tag_r;
    free_nxt = free_r; rot_nxt = rot_r; slot_nxt = slot_r;
    ov_nxt = ov_r; ok_nxt = ok_r; oh_nxt = oh_r; ot_nxt = ot_r; os_nxt = os_r;
    ol_nxt = ol_r;
    mem_we = 1'b0;
    mem_addr = idx;
    mem_wdata = {rot_r, slot_r, tag_r};
    in_ready = 1'b0;
    if (ov_r && out_ready) ov_nxt = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready = !ov_r;
        if (in_valid && !ov_r) begin
          cnt_nxt = '0;
          tag_nxt = in_tag;
          if (in_command) begin
            state_nxt = ST_SCAN_RD;
          end else if (in_timeout[TimeoutW-1]) begin
            ov_nxt = 1'b1; ok_nxt = KIND_REJ_NEG; oh_nxt = '0; ot_nxt = '0;
            os_nxt = '0; ol_nxt = 1'b1;
          end else if (!has_free) begin
            ov_nxt = 1'b1; ok_nxt = KIND_REJ_FULL; oh_nxt = '0; ot_nxt = '0;
            os_nxt = '0; ol_nxt = 1'b1;
          end else begin
            free_nxt = free_idx;
            quo_nxt = in_timeout;
            rem_nxt = '0;
            state_nxt = ST_DIV;
          end
        end
      end
      ST_DIV: begin
        if (!trial[IntvW]) begin
          rem_nxt = trial;
          quo_nxt = {quo_r[TimeoutW-2:0], 1'b1};
        end else begin
          rem_nxt = rem_sh;
          quo_nxt = {quo_r[TimeoutW-2:0], 1'b0};
        end
        cnt_nxt = cnt_r + CntW'(1);
        if (cnt_r == CntW'(TimeoutW - 1)) state_nxt = ST_MOD;
      end
      ST_MOD: begin
        rot_nxt = RotW'(prod >> SlotShift);
        state_nxt = ST_SLOT;
      end
      ST_SLOT: begin
        slot_nxt = (slot_sum >= (SlotW+2)'(NumSlots)) ?
                   SlotW'(slot_sum - (SlotW+2)'(NumSlots)) : SlotW'(slot_sum);
        state_nxt = ST_ADD_WR;
      end
      ST_ADD_WR: begin
        mem_we = 1'b1;
        mem_addr = free_r;
        valid_nxt[free_r] = 1'b1;
        ov_nxt = 1'b1; ok_nxt = KIND_ADDED; oh_nxt = free_r; ot_nxt = '0;
        os_nxt = slot_r; ol_nxt = 1'b1;
        state_nxt = ST_IDLE;
      end
      ST_SCAN_RD: begin
        state_nxt = ST_SCAN_EX;
      end
      ST_SCAN_EX: begin
        if (valid_r[idx] && e_slot == cur_r) begin
          if (e_rot != '0) begin
            mem_we = 1'b1;
            mem_wdata = {e_rot - RotW'(1), e_slot, e_tag};
          end else if (ov_r) begin
            state_nxt = ST_SCAN_EX;
          end else begin
            valid_nxt[idx] = 1'b0;
            ov_nxt = 1'b1; ok_nxt = KIND_EXPIRED; oh_nxt = idx; ot_nxt = e_tag;
            os_nxt = cur_r; ol_nxt = 1'b0;
          end
        end
        if (!(valid_r[idx] && e_slot == cur_r && e_rot == '0 && ov_r)) begin
          cnt_nxt = cnt_r + CntW'(1);
          state_nxt = (cnt_r == CntW'(PoolEntries - 1)) ? ST_DONE : ST_SCAN_RD;
        end
      end
      ST_DONE: begin
        if (!ov_r) begin
          ov_nxt = 1'b1; ok_nxt = KIND_DONE; oh_nxt = '0; ot_nxt = '0;
          os_nxt = cur_r; ol_nxt = 1'b1;
          cur_nxt = (cur_r == SlotW'(NumSlots - 1)) ? '0 : cur_r + SlotW'(1);
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  assign out_valid = ov_r;
  assign out_kind = ok_r;
  assign out_handle = oh_r;
  assign out_expired_tag = ot_r;
  assign out_wheel_slot = os_r;
  assign out_last = ol_r;

  a_slot_range: assert property (@(posedge clk) disable iff (!rst_n)
    cur_r < SlotW'(NumSlots)) else $error("current slot out of range");
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_kind) && $stable(out_handle))
    else $error("result word changed while stalled");
  a_add_sets_valid: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_ADD_WR |=> valid_r[$past(free_r)]) else $error("add lost entry");
  a_busy_no_accept: assert property (@(posedge clk) disable iff (!rst_n)
    state_r != ST_IDLE |-> !in_ready) else $error("accept while busy");
endmodule

### sim/tb_top.sv
// testbench for timing_wheel_scheduler_unit: directed table then random adds and ticks
// predicts every result word with a local wheel model; depends on tws_pkg and the rtl
`timescale 1ns / 100ps

module tb_top;
  import tws_pkg::*;

  typedef struct packed {
    logic [KindW-1:0]   kind;
    logic [HandleW-1:0] handle;
    logic [TagW-1:0]    tag;
    logic [SlotW-1:0]   slot;
    logic               last;
  } word_t;

  typedef struct {
    logic        cmd;
    logic [31:0] tmo;
    logic [15:0] tag;
    logic        chk;
    word_t       want;
  } row_t;

  localparam logic CMD_ADD  = 1'b0;
  localparam logic CMD_TICK = 1'b1;
  localparam int   WDOG     = 20000;

  logic clk = 0, rst_n = 0;
  logic cfg_wr_en = 0;
  logic [IntvW-1:0] cfg_wr_data = '0;
  logic in_valid = 0, in_command = 0;
  logic signed [TimeoutW-1:0] in_timeout = '0;
  logic [TagW-1:0] in_tag = '0;
  logic in_ready, out_valid, out_ready = 0, out_last;
  logic [KindW-1:0] out_kind;
  logic [HandleW-1:0] out_handle;
  logic [TagW-1:0] out_expired_tag;
  logic [SlotW-1:0] out_wheel_slot;

  timing_wheel_scheduler_unit u_dut (.*);

  always begin
    #2 clk = 1;
    #2 clk = 0;
  end

  // wheel model
  logic [15:0]     intv;
  logic [SlotW-1:0] wheel_pos;
  logic            ent_valid [PoolEntries];
  logic [RotW-1:0] ent_rot [PoolEntries];
  logic [SlotW-1:0] ent_slot [PoolEntries];
  logic [TagW-1:0] ent_tag [PoolEntries];
  word_t pending_words [$];
  int errors = 0, idle_cycles = 0;
  bit quiet = 0;

  function automatic word_t mk(logic [2:0] k, int h, logic [15:0] t, int s, logic l);
    word_t w;
    w.kind = k; w.handle = HandleW'(h); w.tag = t; w.slot = SlotW'(s); w.last = l;
    return w;
  endfunction

  task automatic predict_wheel(input logic cmd, input logic [31:0] tmo, input logic [15:0] tg);
    logic [31:0] div, ticks;
    int fr;
    logic [SlotW-1:0] s;
    fr = -1;
    if (cmd == CMD_ADD) begin
      div = (intv == 0) ? 32'd1 : {16'd0, intv};
      if (tmo[31]) begin
        pending_words.push_back(mk(KIND_REJ_NEG, 0, 0, 0, 1));
        return;
      end
      for (int i = PoolEntries - 1; i >= 0; i--) if (!ent_valid[i]) fr = i;
      if (fr < 0) begin
        pending_words.push_back(mk(KIND_REJ_FULL, 0, 0, 0, 1));
        return;
      end
      ticks = tmo / div;
      s = SlotW'((wheel_pos + ticks % NumSlots) % NumSlots);
      ent_valid[fr] = 1;
      ent_rot[fr] = RotW'(ticks / NumSlots);
      ent_slot[fr] = s;
      ent_tag[fr] = tg;
      pending_words.push_back(mk(KIND_ADDED, fr, 0, s, 1));
    end else begin
      for (int i = 0; i < PoolEntries; i++) begin
        if (ent_valid[i] && ent_slot[i] == wheel_pos) begin
          if (ent_rot[i] > 0) ent_rot[i]--;
          else begin
            pending_words.push_back(mk(KIND_EXPIRED, i, ent_tag[i], wheel_pos, 0));
            ent_valid[i] = 0;
          end
        end
      end
      pending_words.push_back(mk(KIND_DONE, 0, 0, wheel_pos, 1));
      wheel_pos = SlotW'((wheel_pos + 1) % NumSlots);
    end
  endtask

  // result checker and receiver stalls
  int stall = 0;
  always @(posedge clk) begin
    word_t got, exp_w;
    if (in_valid && in_ready || out_valid && out_ready) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (out_valid && out_ready) begin
      got = {out_kind, out_handle, out_expired_tag, out_wheel_slot, out_last};
      if (pending_words.size() == 0) begin
        $display("%0t unexpected word %h", $time, got);
        errors++;
      end else begin
        exp_w = pending_words.pop_front();
        if (got !== exp_w) begin
          $display("%0t mismatch expected %h actual %h", $time, exp_w, got);
          errors++;
        end
      end
    end
  end

  always @(negedge clk) begin
    if (quiet || !rst_n) out_ready <= rst_n;
    else if (stall > 0) begin
      stall--;
      out_ready <= 0;
    end else if ($urandom_range(0, 5) == 0) begin
      stall = $urandom_range(1, 6) - 1;
      out_ready <= 0;
    end else out_ready <= 1;
  end

  always @(posedge clk) begin
    if (idle_cycles >= WDOG) begin
      $display("tb_top: FAIL");
      $finish;
    end
  end

  task automatic send(input logic cmd, input logic [31:0] tmo, input logic [15:0] tg);
    if (!quiet && $urandom_range(0, 4) == 0) begin
      in_valid <= 0;
      repeat ($urandom_range(1, 6)) @(negedge clk);
    end
    in_valid <= 1; in_command <= cmd; in_timeout <= tmo; in_tag <= tg;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predict_wheel(cmd, tmo, tg);
    @(negedge clk);
  endtask

  task automatic write_interval(input logic [15:0] v);
    in_valid <= 0;
    while (pending_words.size() != 0) @(negedge clk);
    repeat (80) @(negedge clk);
    cfg_wr_en <= 1; cfg_wr_data <= v;
    @(negedge clk);
    cfg_wr_en <= 0;
    intv = v;
  endtask

  row_t rows [$];
  function automatic row_t r(logic c, logic [31:0] t, logic [15:0] g, logic k = 0,
                             word_t w = '0);
    row_t x;
    x.cmd = c; x.tmo = t; x.tag = g; x.chk = k; x.want = w;
    return x;
  endfunction

  initial begin
    logic [15:0] ivs [4];
    intv = 1; wheel_pos = 0;
    foreach (ent_valid[i]) begin
      ent_valid[i] = 0; ent_rot[i] = 0; ent_slot[i] = 0; ent_tag[i] = 0;
    end
    repeat (10) @(negedge clk);
    rst_n <= 1;
    @(negedge clk);
    rows.push_back(r(CMD_ADD, 32'd0, 16'hffff, 1, mk(KIND_ADDED, 0, 0, 0, 1)));
    rows.push_back(r(CMD_ADD, 32'h8000_0000, 16'h1234, 1, mk(KIND_REJ_NEG, 0, 0, 0, 1)));
    rows.push_back(r(CMD_ADD, 32'hffff_ffff, 16'h0, 1, mk(KIND_REJ_NEG, 0, 0, 0, 1)));
    rows.push_back(r(CMD_ADD, 32'h7fff_ffff, 16'h0000));
    rows.push_back(r(CMD_ADD, 32'd9, 16'haaaa));
    rows.push_back(r(CMD_ADD, 32'd10, 16'h5555));
    rows.push_back(r(CMD_TICK, 32'hffff_ffff, 16'hffff, 1, mk(KIND_EXPIRED, 0, 16'hffff, 0, 0)));
    rows.push_back(r(CMD_TICK, 32'd0, 16'd0));
    for (int i = 0; i < 10; i++) rows.push_back(r(CMD_TICK, 32'd0, 16'd0));
    foreach (rows[i]) begin
      if (rows[i].chk && pending_words.size() == 0)
        ; // expectation is typed in; model must agree with it
      send(rows[i].cmd, rows[i].tmo, rows[i].tag);
      if (rows[i].chk && pending_words[0] !== rows[i].want) begin
        $display("%0t mismatch expected %h actual %h", $time, rows[i].want, pending_words[0]);
        errors++;
      end
    end
    // fill the pool to reach the full rejection, then advance the wheel
    for (int i = 0; i < 34; i++) send(CMD_ADD, $urandom_range(0, 40), 16'($urandom));
    for (int i = 0; i < 12; i++) send(CMD_TICK, $urandom, 16'($urandom));
    ivs[0] = 16'hffff; ivs[1] = 16'd0; ivs[2] = 16'd3; ivs[3] = 16'd1;
    for (int p = 0; p < 4; p++) begin
      write_interval(ivs[p]);
      for (int i = 0; i < 100; i++) begin
        logic [31:0] t;
        case ($urandom_range(0, 5))
          0: t = $urandom;
          1: t = $urandom_range(0, 200) * (intv == 0 ? 1 : intv);
          2: t = {1'b0, 31'($urandom)};
          default: t = $urandom_range(0, 60);
        endcase
        if (p == 3 && i >= 70) quiet = 1;
        send($urandom_range(0, 2) == 0 ? CMD_TICK : CMD_ADD, t, 16'($urandom));
      end
    end
    for (int i = 0; i < 8; i++) send(CMD_TICK, $urandom, 16'($urandom));
    in_valid <= 0;
    while (pending_words.size() != 0) @(negedge clk);
    repeat (100) @(negedge clk);
    if (errors == 0) $display("tb_top: PASS");
    else $display("tb_top: FAIL");
    $finish;
  end
endmodule
